>>> rtl/direct_mapped_hashed_key_cache_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hashed key cache
// Shared helpers for concurrent assertions with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_HASHED_KEY_CACHE_TOP_DEFINES_SVH
`define DIRECT_MAPPED_HASHED_KEY_CACHE_TOP_DEFINES_SVH

// check a property on every clock edge outside reset
`define DMHKC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// check a property on every clock edge, reset included
`define DMHKC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

>>> rtl/dmhkc_pkg.sv
// ---------------------------------------------------------------------------
// Hashed key cache package
// Field widths, operation and status codes shared by the cache files.
// ---------------------------------------------------------------------------
package dmhkc_pkg;

   localparam int HASH_W  = 32;
   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int CFG_W   = 9;
   localparam int SLOT_W  = 8;
   localparam int STAT_W  = 2;

   typedef enum logic [STAT_W-1:0] {
      STATUS_MISS     = 2'd0,
      STATUS_HIT      = 2'd1,
      STATUS_INSERTED = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } status_type;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   // sdbm step: b + h*65599, wrapping at 32 bits
   function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      mix_byte = HASH_W'(b) + (h << 6) + (h << 16) - h;
   endfunction

endpackage

>>> rtl/dmhkc_if.sv
// ---------------------------------------------------------------------------
// Hashed key cache channels
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface dmhkc_req_if;
   import dmhkc_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [WORD_W-1:0] tree_id;
   logic [WORD_W-1:0] node_id;
   logic [WORD_W-1:0] tag;
   logic [BYTE_W-1:0] key_byte;
   logic              byte_present;
   logic              last_byte;
   logic [WORD_W-1:0] data_handle;
   modport source (output valid, mode, tree_id, node_id, tag, key_byte, byte_present,
                   last_byte, data_handle, input ready);
   modport sink   (input valid, mode, tree_id, node_id, tag, key_byte, byte_present,
                   last_byte, data_handle, output ready);
endinterface

interface dmhkc_rsp_if;
   import dmhkc_pkg::*;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [WORD_W-1:0] found_value;
   logic [SLOT_W-1:0] slot_index;
   modport source (output valid, status, found_value, slot_index, input ready);
   modport sink   (input valid, status, found_value, slot_index, output ready);
endinterface

interface dmhkc_csr_if;
   import dmhkc_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] entries_in_use;
   modport source (output valid, entries_in_use, input ready);
   modport sink   (input valid, entries_in_use, output ready);
endinterface

>>> rtl/dmhkc_mod_unit.sv
// ---------------------------------------------------------------------------
// Hashed key cache modulo unit
// Restoring remainder of a 32-bit hash by the slot count, one bit a cycle.
// ---------------------------------------------------------------------------
module dmhkc_mod_unit #(
   parameter int MW = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dmhkc_pkg::HASH_W-1:0]  dividend,
   input  logic [MW-1:0]                 divisor,
   output logic                          done,
   output logic [MW-1:0]                 remainder
);
   import dmhkc_pkg::*;

   localparam int NW = $clog2(HASH_W);

   logic              busy_ff, busy_in;
   logic [NW-1:0]     step_ff, step_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [MW-1:0]     rem_ff, rem_in;
   logic [MW-1:0]     div_ff, div_in;
   logic [MW:0]       trial;
   logic              fin;

   always_comb begin
      trial   = {rem_ff, dvd_ff[HASH_W-1]};
      busy_in = busy_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      fin     = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = MW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[MW-1:0];
         end
         dvd_in  = dvd_ff << 1;
         step_in = step_ff + 1'b1;
         if (step_ff == NW'(HASH_W - 1)) begin
            busy_in = 1'b0;
            fin     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done    <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done    <= fin;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign remainder = rem_ff;

endmodule

>>> rtl/direct_mapped_hashed_key_cache_top.sv
// ---------------------------------------------------------------------------
// Direct-mapped hashed key cache
// Key bytes stream in one beat each; the last beat looks up or inserts.
// ---------------------------------------------------------------------------
// A key is tree_id, node_id, tag and up to MAX_KEY_BYTES bytes, at most one
// byte per request beat. A beat that is not the last of its key is taken
// at once and the next beat can follow straight away. The last beat starts
// the operation: a restoring modulo unit reduces the 32-bit sdbm hash by
// the slot count and hands over the remainder, then a lookup reads the slot
// record and compares the key bytes one by one from the key byte memory,
// and an insert writes the slot record and stores the key bytes one at a
// time (a key with no bytes still takes one store step). The result beat
// then waits in the output register until taken, and the next key is
// accepted after that. Keys longer than MAX_KEY_BYTES answer "too long"
// and leave the table alone. After reset the block runs a clearing pass
// over the valid bits of all ENTRIES slots, one slot a cycle, with req
// ready low; register writes are taken at any time but must only happen
// while idle. entries_in_use of 0 or above ENTRIES acts as ENTRIES.
// ---------------------------------------------------------------------------
module direct_mapped_hashed_key_cache_top #(
   parameter int ENTRIES       = 256,
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic     clock,
   input  logic     reset,
   dmhkc_req_if.sink   req_chan,
   dmhkc_rsp_if.source rsp_chan,
   dmhkc_csr_if.sink   csr_chan
);
   import dmhkc_pkg::*;

   localparam int SW  = $clog2(ENTRIES);
   localparam int CW  = $clog2(MAX_KEY_BYTES + 1);
   localparam int JW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int MWE = $clog2(ENTRIES + 1);
   localparam int MW  = (MWE > CFG_W) ? MWE : CFG_W;
   localparam int KD  = ENTRIES << JW;

   typedef struct packed {
      logic [WORD_W-1:0] tree;
      logic [WORD_W-1:0] node;
      logic [WORD_W-1:0] tag;
      logic [CW-1:0]     length;
      logic [WORD_W-1:0] value;
   } meta_type;

   typedef struct packed {
      logic              mode;
      logic [WORD_W-1:0] tree;
      logic [WORD_W-1:0] node;
      logic [WORD_W-1:0] tag;
      logic [WORD_W-1:0] data;
   } op_type;

   typedef enum logic [8:0] {
      S_CLEAR   = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_DIVIDE  = 9'b000000100,
      S_META    = 9'b000001000,
      S_MATCH   = 9'b000010000,
      S_KWAIT   = 9'b000100000,
      S_KCMP    = 9'b001000000,
      S_STORE   = 9'b010000000,
      S_RESPOND = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  entries_ff;
   logic [HASH_W-1:0] hash_ff, hash_in, hash_new, h_base;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in, ovf_new;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     kidx_ff, kidx_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [SW-1:0]     clr_ff, clr_in;
   op_type            op_ff, op_in;
   logic [BYTE_W-1:0] pending_ff [MAX_KEY_BYTES];
   logic              pend_we;

   status_type        status_ff, status_in;
   logic [WORD_W-1:0] found_ff, found_in;
   logic [SLOT_W-1:0] slot_out_ff, slot_out_in;

   logic [MW-1:0]     modulus;
   logic              accept, div_start, div_done;
   logic [MW-1:0]     div_rem;

   // slot record, valid bits and key bytes live in memories
   meta_type          meta_mem [ENTRIES];
   logic              valid_mem [ENTRIES];
   logic [BYTE_W-1:0] key_mem [KD];
   meta_type          meta_rd_ff;
   logic              valid_rd_ff;
   logic [BYTE_W-1:0] key_rd_ff;
   logic              meta_we, valid_we, valid_wd, key_we;
   logic [SW-1:0]     valid_wa;
   logic              meta_ok;

   // hold the register; the user must write it only while idle, which the block does not enforce
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CFG_W'(256);
      end else if (csr_chan.valid) begin
         entries_ff <= csr_chan.entries_in_use;
      end
   end

   always_comb begin
      if (entries_ff == '0 || MW'(entries_ff) > MW'(ENTRIES)) begin
         modulus = MW'(ENTRIES);
      end else begin
         modulus = MW'(entries_ff);
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // fold one key byte into the running hash; seed on the first beat of a key
   always_comb begin
      h_base   = (count_ff == '0 && !ovf_ff) ?
                 (req_chan.tree_id ^ req_chan.node_id ^ req_chan.tag) : hash_ff;
      hash_new = h_base;
      count_in = count_ff;
      ovf_new  = ovf_ff;
      pend_we  = 1'b0;
      if (req_chan.byte_present) begin
         if (count_ff < CW'(MAX_KEY_BYTES)) begin
            hash_new = mix_byte(h_base, req_chan.key_byte);
            count_in = count_ff + 1'b1;
            pend_we  = accept;
         end else begin
            ovf_new = 1'b1;
         end
      end
   end

   assign div_start = accept && req_chan.last_byte && !ovf_new;

   dmhkc_mod_unit #(.MW(MW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hash_new),
      .divisor   (modulus),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign meta_ok = valid_rd_ff && meta_rd_ff.tree == op_ff.tree &&
                    meta_rd_ff.node == op_ff.node && meta_rd_ff.tag == op_ff.tag &&
                    meta_rd_ff.length == len_ff;

   always_comb begin
      state_in    = state_ff;
      hash_in     = hash_ff;
      ovf_in      = ovf_ff;
      len_in      = len_ff;
      kidx_in     = kidx_ff;
      slot_in     = slot_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      slot_out_in = slot_out_ff;
      meta_we     = 1'b0;
      valid_we    = 1'b0;
      valid_wd    = 1'b0;
      valid_wa    = slot_ff;
      key_we      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            valid_we = 1'b1;
            valid_wa = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == SW'(ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               hash_in = hash_new;
               ovf_in  = ovf_new;
               if (req_chan.last_byte) begin
                  // drop the running key; the operation works from the latches
                  hash_in  = '0;
                  ovf_in   = 1'b0;
                  len_in   = count_in;
                  op_in    = '{mode: req_chan.mode, tree: req_chan.tree_id,
                               node: req_chan.node_id, tag: req_chan.tag,
                               data: req_chan.data_handle};
                  if (ovf_new) begin
                     status_in   = STATUS_TOO_LONG;
                     found_in    = '0;
                     slot_out_in = '0;
                     state_in    = S_RESPOND;
                  end else begin
                     state_in = S_DIVIDE;
                  end
               end
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               slot_in     = div_rem[SW-1:0];
               slot_out_in = SLOT_W'(div_rem[SW-1:0]);
               kidx_in     = '0;
               state_in    = (op_ff.mode == MODE_INSERT) ? S_STORE : S_META;
            end
         end
         S_META: begin
            state_in = S_MATCH;
         end
         S_MATCH: begin
            found_in = '0;
            kidx_in  = '0;
            if (!meta_ok) begin
               status_in = STATUS_MISS;
               state_in  = S_RESPOND;
            end else if (len_ff == '0) begin
               status_in = STATUS_HIT;
               found_in  = meta_rd_ff.value;
               state_in  = S_RESPOND;
            end else begin
               state_in = S_KWAIT;
            end
         end
         S_KWAIT: begin
            state_in = S_KCMP;
         end
         S_KCMP: begin
            if (key_rd_ff != pending_ff[kidx_ff[JW-1:0]]) begin
               status_in = STATUS_MISS;
               state_in  = S_RESPOND;
            end else if ((kidx_ff + 1'b1) == len_ff) begin
               status_in = STATUS_HIT;
               found_in  = meta_rd_ff.value;
               state_in  = S_RESPOND;
            end else begin
               kidx_in  = kidx_ff + 1'b1;
               state_in = S_KWAIT;
            end
         end
         S_STORE: begin
            key_we = (kidx_ff < len_ff);
            if (kidx_ff == '0) begin
               meta_we  = 1'b1;
               valid_we = 1'b1;
               valid_wd = 1'b1;
            end
            if ({1'b0, kidx_ff} + 1'b1 >= {1'b0, len_ff}) begin
               status_in = STATUS_INSERTED;
               found_in  = '0;
               state_in  = S_RESPOND;
            end else begin
               kidx_in = kidx_ff + 1'b1;
            end
         end
         S_RESPOND: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         hash_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         hash_ff  <= hash_in;
         ovf_ff   <= ovf_in;
         if (accept) begin
            count_ff <= req_chan.last_byte ? '0 : count_in;
         end
      end
      len_ff      <= len_in;
      kidx_ff     <= kidx_in;
      slot_ff     <= slot_in;
      op_ff       <= op_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      slot_out_ff <= slot_out_in;
      if (pend_we) begin
         pending_ff[count_ff[JW-1:0]] <= req_chan.key_byte;
      end
   end

   // memories: one write port and one registered read port each
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[slot_ff] <= '{tree: op_ff.tree, node: op_ff.node, tag: op_ff.tag,
                                length: len_ff, value: op_ff.data};
      end
      meta_rd_ff <= meta_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (valid_we) begin
         valid_mem[valid_wa] <= valid_wd;
      end
      valid_rd_ff <= valid_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[{slot_ff, kidx_ff[JW-1:0]}] <= pending_ff[kidx_ff[JW-1:0]];
      end
      key_rd_ff <= key_mem[{slot_ff, kidx_ff[JW-1:0]}];
   end

   assign rsp_chan.valid       = (state_ff == S_RESPOND);
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.found_value = found_ff;
   assign rsp_chan.slot_index  = slot_out_ff;

endmodule

>>> rtl/dmhkc_checker.sv
// ---------------------------------------------------------------------------
// Hashed key cache port checker
// Watches the top level's ports and flags illegal result beats.
// ---------------------------------------------------------------------------
`include "direct_mapped_hashed_key_cache_top_defines.svh"

module dmhkc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dmhkc_pkg::STAT_W-1:0]  rsp_status,
   input logic [dmhkc_pkg::WORD_W-1:0]  rsp_found_value,
   input logic [dmhkc_pkg::SLOT_W-1:0]  rsp_slot_index
);
   import dmhkc_pkg::*;

   // only a hit carries a value
   `DMHKC_ASSERT(a_found_only_on_hit, clock, reset, rsp_valid && rsp_status != STATUS_HIT |-> rsp_found_value == '0)
   // an overlong key names no slot
   `DMHKC_ASSERT(a_too_long_slot_zero, clock, reset, rsp_valid && rsp_status == STATUS_TOO_LONG |-> rsp_slot_index == '0)
   // the clearing pass holds off requests right after reset
   `DMHKC_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_ready)
   // a stalled result beat holds
   `DMHKC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found_value) && $stable(rsp_slot_index))

endmodule

bind direct_mapped_hashed_key_cache_top dmhkc_checker u_dmhkc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_found_value (rsp_chan.found_value),
   .rsp_slot_index  (rsp_chan.slot_index)
);
